// ===== src/bor_pkg.sv =====
// Package for the optimal-replacement cache simulator: request and result types.
// No dependencies.
package bor_pkg;
	localparam int unsigned PageW = 16;
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdRequest = 1'b1;

	typedef struct packed {
		logic command;
		logic [PageW-1:0] page_id;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic [PageW-1:0] req_page;
		logic evicted;
		logic [PageW-1:0] evicted_page;
	} out_item_t;

	// Commands from the sequencer to the cell row.
	typedef struct packed {
		logic clear_found;
		logic compare;
		logic shift_all;
	} cell_ctl_t;
endpackage

// ===== src/belady_optimal_replacement_unit.sv =====
// Top level of the optimal-replacement cache simulator.
// Depends on bor_pkg, bor_ram and bor_cell.
//
// A load is accepted without leaving the idle state, and the next request can
// follow at once. A request first checks all slots at once against the page; a
// hit or a fill of a free slot answers without a scan. A miss with a full cache
// streams the future trace out of the trace RAM, one entry a cycle, past a row of
// WAYS slot cells that each latch their first next use; the stream stops early
// once every slot has been found, and a walk over the cells then picks the
// farthest victim. The trace RAM's single port sets the scan rate. No clearing
// pass is needed after reset.
module belady_optimal_replacement_unit #(
	parameter int unsigned WAYS = 64,
	parameter int unsigned TRACE_DEPTH = 4096,
	parameter int unsigned ID_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bor_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output bor_pkg::out_item_t out_data
);
	localparam int unsigned PosW = $clog2(TRACE_DEPTH + 1);
	localparam int unsigned AddrW = $clog2(TRACE_DEPTH);
	localparam int unsigned WayW = $clog2(WAYS);
	localparam int unsigned CntW = $clog2(WAYS + 1);
	localparam int unsigned PW = bor_pkg::PageW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOK, ST_SCAN, ST_DRAIN, ST_PICK, ST_SHIFT, ST_OUT
	} state_t;

	state_t state_q;
	logic [ID_BITS-1:0] page_q;
	logic [PosW-1:0] len_q, pos_q, rd_idx_q;
	logic last_load_q;
	logic [CntW-1:0] count_q;
	logic [WayW-1:0] target_q, walk_q, best_q;
	logic best_inf_q;
	logic [PosW-1:0] best_pos_q;
	logic hit_q, ev_q;
	logic [ID_BITS-1:0] ev_page_q;
	logic rd_valid_s1, rd_valid_s2;
	logic [PosW-1:0] rd_pos_s1, rd_pos_s2;
	logic [ID_BITS-1:0] rd_page_s2;
	bor_pkg::out_item_t out_q;
	logic out_valid_q;

	// Trace RAM port.
	logic ram_we;
	logic [AddrW-1:0] ram_addr;
	logic [ID_BITS-1:0] ram_rdata;
	logic [PosW-1:0] len_base;

	assign len_base = last_load_q ? len_q : '0;
	assign ram_we = (state_q == ST_IDLE) && in_valid && in_ready
		&& (in_data.command == bor_pkg::CmdLoad) && (len_base < PosW'(TRACE_DEPTH));
	assign ram_addr = ram_we ? len_base[AddrW-1:0] : rd_idx_q[AddrW-1:0];

	bor_ram #(.WIDTH(ID_BITS), .DEPTH(TRACE_DEPTH)) u_trace (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(in_data.page_id[ID_BITS-1:0]), .rdata(ram_rdata)
	);

	// Cell row.
	bor_pkg::cell_ctl_t ctl;
	logic [ID_BITS-1:0] cell_page [WAYS];
	logic [PosW-1:0] cell_use [WAYS];
	logic [WAYS-1:0] cell_match, cell_found, cell_occ, cell_lk, cell_shift;
	logic [ID_BITS-1:0] probe;
	logic all_found;

	assign probe = (state_q == ST_SCAN || state_q == ST_DRAIN) ? rd_page_s2 : page_q;
	assign all_found = (cell_found | (cell_match & {WAYS{rd_valid_s2}})) == {WAYS{1'b1}};

	// The row moves only in the cycle that hands the result to the output register.
	always_comb begin
		ctl = '0;
		ctl.clear_found = (state_q == ST_LOOK);
		ctl.compare = (state_q == ST_SCAN || state_q == ST_DRAIN) && rd_valid_s2;
		ctl.shift_all = (state_q == ST_SHIFT) && (!out_valid_q || out_ready);
	end

	for (genvar g = 0; g < WAYS; g++) begin : g_cell
		assign cell_occ[g] = CntW'(g) < count_q;
		assign cell_shift[g] = ctl.shift_all && (WayW'(g) <= target_q);
		bor_cell #(.ID_BITS(ID_BITS), .POS_BITS(PosW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .occupied(cell_occ[g]),
			.probe(probe), .probe_pos(rd_pos_s2), .shift_en(cell_shift[g]),
			.prev_page(cell_page[(g == 0) ? 0 : g - 1]), .new_page(page_q),
			.is_head(g == 0), .page(cell_page[g]), .match(cell_match[g]),
			.found(cell_found[g]), .next_use(cell_use[g])
		);
	end

	// Lowest matching slot on lookup.
	logic [WayW-1:0] hit_idx;
	always_comb begin
		hit_idx = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit_idx = WayW'(i);
			end
		end
	end
	assign cell_lk = cell_match;

	logic [PosW-1:0] stop_pos;
	assign stop_pos = len_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Sequencer: holds state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			pos_q <= '0;
			last_load_q <= 1'b0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_valid_s2 <= 1'b0;
			page_q <= '0;
			rd_idx_q <= '0;
			target_q <= '0;
			walk_q <= '0;
			best_q <= '0;
			best_inf_q <= 1'b0;
			best_pos_q <= '0;
			hit_q <= 1'b0;
			ev_q <= 1'b0;
			ev_page_q <= '0;
			rd_pos_s1 <= '0;
			rd_pos_s2 <= '0;
			rd_page_s2 <= '0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s2 <= rd_valid_s1;
			rd_pos_s2 <= rd_pos_s1;
			rd_page_s2 <= ram_rdata;
			rd_valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						page_q <= in_data.page_id[ID_BITS-1:0];
						if (in_data.command == bor_pkg::CmdLoad) begin
							if (len_base < PosW'(TRACE_DEPTH)) begin
								len_q <= len_base + PosW'(1);
							end else begin
								len_q <= len_base;
							end
							if (!last_load_q) begin
								pos_q <= '0;
							end
							last_load_q <= 1'b1;
						end else begin
							last_load_q <= 1'b0;
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					hit_q <= |cell_lk;
					ev_q <= 1'b0;
					ev_page_q <= '0;
					if (|cell_lk) begin
						target_q <= hit_idx;
						state_q <= ST_SHIFT;
					end else if (count_q < CntW'(WAYS)) begin
						target_q <= count_q[WayW-1:0];
						count_q <= count_q + CntW'(1);
						state_q <= ST_SHIFT;
					end else begin
						rd_idx_q <= pos_q + PosW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ctl.compare && all_found) begin
						state_q <= ST_DRAIN;
					end else if (rd_idx_q < stop_pos) begin
						rd_valid_s1 <= 1'b1;
						rd_pos_s1 <= rd_idx_q;
						rd_idx_q <= rd_idx_q + PosW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !rd_valid_s2) begin
						walk_q <= '0;
						best_q <= '0;
						best_inf_q <= 1'b0;
						best_pos_q <= '0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!best_inf_q && (!cell_found[walk_q]
							|| cell_use[walk_q] > best_pos_q)) begin
						best_q <= walk_q;
						best_inf_q <= !cell_found[walk_q];
						best_pos_q <= cell_use[walk_q];
					end
					if (walk_q == WayW'(WAYS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						walk_q <= walk_q + WayW'(1);
					end
				end
				ST_OUT: begin
					target_q <= best_q;
					ev_q <= 1'b1;
					ev_page_q <= cell_page[best_q];
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.hit <= hit_q;
						out_q.req_page <= PW'(page_q);
						out_q.evicted <= ev_q;
						out_q.evicted_page <= PW'(ev_page_q);
						if (pos_q < PosW'(TRACE_DEPTH)) begin
							pos_q <= pos_q + PosW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== src/bor_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bor_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One access a cycle; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== src/bor_cell.sv =====
// One cache slot cell: holds a page, its next-use mark and found flag.
// Depends on bor_pkg.
module bor_cell #(
	parameter int unsigned ID_BITS = 16,
	parameter int unsigned POS_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  bor_pkg::cell_ctl_t ctl,
	input  logic occupied,
	input  logic [ID_BITS-1:0] probe,
	input  logic [POS_BITS-1:0] probe_pos,
	input  logic shift_en,
	input  logic [ID_BITS-1:0] prev_page,
	input  logic [ID_BITS-1:0] new_page,
	input  logic is_head,
	output logic [ID_BITS-1:0] page,
	output logic match,
	output logic found,
	output logic [POS_BITS-1:0] next_use
);
	logic [ID_BITS-1:0] page_q;
	logic [POS_BITS-1:0] next_use_q;
	logic found_q;

	assign page = page_q;
	assign next_use = next_use_q;
	assign found = found_q;
	assign match = occupied && (page_q == probe);

	// Page register takes its lower neighbor's page during a shift away from the head; the head takes the new page.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			page_q <= is_head ? new_page : prev_page;
		end
		if (ctl.compare && !found_q && match) begin
			next_use_q <= probe_pos;
		end
	end

	// Found flag is cleared by reset and in each request's lookup, ahead of any victim scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear_found) begin
			found_q <= 1'b0;
		end else if (ctl.compare && match) begin
			found_q <= 1'b1;
		end
	end
endmodule
